FILE: sv/assert_macros.svh
// Assertion macros shared by the bounding sphere RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define IBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: sv/ibs_pkg.sv
// Package with the payload types and command codes of the bounding sphere unit.
package ibs_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned COORD_WIDTH = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0, CFG_MIN_Y = 3'd1, CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3, CFG_MAX_Y = 3'd4, CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [31:0] sphere_radius;
        logic               grew;
        logic               final_sphere;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture input item
        logic init;      // start sphere from box
        logic diff;      // point minus center, magnitudes
        logic sq;        // one axis square, accumulate (axis in sel)
        logic [1:0] sel;
        logic cmp;       // compare distance with radius
        logic sqrt_start;
        logic sqrt_step;
        logic sqrt_fin;
        logic div_start;
        logic div_step;
        logic mul;       // one axis move product (axis in sel)
        logic upd;       // apply move to one axis (axis in sel)
        logic rad;       // new radius
        logic rsq;       // radius squared
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic outside;
        logic last;
    } t_sts;
endpackage

FILE: sv/ibs_datapath.sv
// Datapath of the bounding sphere unit: registers, multipliers, root and divide steps.
module ibs_datapath (
    input  logic              i_clk,
    input  ibs_pkg::t_in_item i_item,
    input  ibs_pkg::t_cmd     i_cmd,
    input  logic signed [31:0] i_box_min [3],
    input  logic signed [31:0] i_box_max [3],
    output ibs_pkg::t_sts     o_sts,
    output ibs_pkg::t_out_item o_item
);
    import ibs_pkg::*;

    logic signed [31:0] r_p [3];
    logic               r_last;
    logic signed [31:0] r_c [3];
    logic [31:0]        r_rad;
    logic [63:0]        r_rsq;
    logic signed [33:0] r_dv [3];
    logic [32:0]        r_mag [3];
    logic [65:0]        r_dsq;
    logic               r_grew;
    logic [65:0]        r_sq_src;
    logic [33:0]        r_root;
    logic [34:0]        r_srem;
    logic [34:0]        r_drem;
    logic [34:0]        r_den;
    logic [31:0]        r_fac;
    logic [64:0]        r_prod;
    t_out_item          r_out;

    logic signed [33:0] s_sum;
    logic [34:0]        s_rem2;
    logic [34:0]        s_trial;
    logic [34:0]        s_dsh;
    logic [65:0]        s_msq;
    logic [34:0]        s_d;
    logic [33:0]        s_nr;

    // Root step: bring down two bits, try subtracting 4*root+1.
    assign s_rem2  = {r_srem[32:0], r_sq_src[65:64]};
    assign s_trial = {r_root[32:0], 2'b01};
    assign s_dsh   = {r_drem[33:0], 1'b0};
    assign s_d     = {1'b0, r_root} + {34'd0, (r_srem != '0)};

    // Shared square of one axis magnitude.
    assign s_msq = r_mag[i_cmd.sel] * r_mag[i_cmd.sel];

    always_comb begin
        logic signed [34:0] step;
        step = $signed({2'b00, r_prod[64:32]});
        if (r_dv[i_cmd.sel] < 0) s_sum = 34'(r_c[i_cmd.sel] - step);
        else s_sum = 34'(r_c[i_cmd.sel] + step);
    end
    assign s_nr  = ({2'b00, r_rad} + s_d[33:0] + 34'd1) >> 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p[0] <= i_item.point_x;
            r_p[1] <= i_item.point_y;
            r_p[2] <= i_item.point_z;
            r_last <= i_item.last_point;
            r_grew <= 1'b0;
        end
        // Box start sphere: midpoint and half the largest extent.
        if (i_cmd.init) begin
            logic [32:0] e [3];
            logic [32:0] m;
            for (int a = 0; a < 3; a++) begin
                logic signed [32:0] s;
                s = 33'(i_box_min[a]) + 33'(i_box_max[a]);
                r_c[a] <= s[32:1];
                e[a] = (i_box_max[a] > i_box_min[a])
                     ? 33'(34'(i_box_max[a]) - 34'(i_box_min[a])) : 33'd0;
            end
            m = e[0];
            if (e[1] > m) m = e[1];
            if (e[2] > m) m = e[2];
            r_rad <= m[32:1];
        end
        if (i_cmd.diff) begin
            for (int a = 0; a < 3; a++) begin
                logic signed [33:0] d;
                d = 34'(r_p[a]) - 34'(r_c[a]);
                r_dv[a]  <= d;
                r_mag[a] <= d < 0 ? 33'(-d) : 33'(d);
            end
            r_dsq <= '0;
        end
        if (i_cmd.sq) r_dsq <= r_dsq + s_msq;
        if (i_cmd.rsq) r_rsq <= r_rad * r_rad;
        if (i_cmd.cmp) r_grew <= (r_dsq > {2'b00, r_rsq});
        if (i_cmd.sqrt_start) begin
            r_sq_src <= r_dsq;
            r_root   <= '0;
            r_srem   <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_sq_src <= {r_sq_src[63:0], 2'b00};
            if (s_rem2 >= s_trial) begin
                r_srem <= s_rem2 - s_trial;
                r_root <= {r_root[32:0], 1'b1};
            end else begin
                r_srem <= s_rem2;
                r_root <= {r_root[32:0], 1'b0};
            end
        end
        if (i_cmd.sqrt_fin) begin
            r_root <= s_d[33:0];
            r_srem <= '0;
        end
        // Fraction (d - r) / (2d), one bit per step.
        if (i_cmd.div_start) begin
            r_drem <= {1'b0, r_root} - {3'b000, r_rad};
            r_den  <= {r_root, 1'b0};
            r_fac  <= '0;
        end
        if (i_cmd.div_step) begin
            if (s_dsh >= r_den) begin
                r_drem <= s_dsh - r_den;
                r_fac  <= {r_fac[30:0], 1'b1};
            end else begin
                r_drem <= s_dsh;
                r_fac  <= {r_fac[30:0], 1'b0};
            end
        end
        if (i_cmd.mul) r_prod <= r_mag[i_cmd.sel] * r_fac;
        if (i_cmd.upd) begin
            if (s_sum > 34'sh7FFFFFFF) r_c[i_cmd.sel] <= 32'sh7FFFFFFF;
            else if (s_sum < -34'sh80000000) r_c[i_cmd.sel] <= -32'sh80000000;
            else r_c[i_cmd.sel] <= s_sum[31:0];
        end
        if (i_cmd.rad) r_rad <= (s_nr > 34'hFFFFFFFF) ? 32'hFFFFFFFF : s_nr[31:0];
        if (i_cmd.out_load) begin
            r_out.center_x      <= r_c[0];
            r_out.center_y      <= r_c[1];
            r_out.center_z      <= r_c[2];
            r_out.sphere_radius <= r_rad;
            r_out.grew          <= r_grew;
            r_out.final_sphere  <= r_last;
        end
    end

    assign o_sts.outside = r_grew;
    assign o_sts.last    = r_last;
    assign o_item        = r_out;
endmodule

FILE: sv/ibs_ctrl.sv
// Controller state machine sequencing one point through the datapath.
module ibs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ibs_pkg::t_sts i_sts,
    output ibs_pkg::t_cmd o_cmd
);
    import ibs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQ, S_RSQ, S_CMP, S_DEC, S_ROOT, S_RFIN,
        S_DSTART, S_DIV, S_MUL, S_UPD, S_RAD, S_DONE
    } t_state;

    t_state      r_state;
    logic        r_open;
    logic [5:0]  r_cnt;
    logic        r_out_valid;

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    // Commands decoded from state; the radius square follows the box start.
    always_comb begin
        o_cmd = '0;
        o_cmd.sel = r_cnt[1:0];
        o_cmd.load = (r_state == S_IDLE) && i_in_valid && !o_in_stall;
        o_cmd.init = o_cmd.load && !r_open;
        case (r_state)
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                o_cmd.rsq  = 1'b1;
            end
            S_SQ:     o_cmd.sq = 1'b1;
            S_CMP:    o_cmd.cmp = 1'b1;
            S_DEC:    o_cmd.sqrt_start = i_sts.outside;
            S_ROOT:   o_cmd.sqrt_step = 1'b1;
            S_RFIN:   o_cmd.sqrt_fin = 1'b1;
            S_DSTART: o_cmd.div_start = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_MUL:    o_cmd.mul = 1'b1;
            S_UPD:    o_cmd.upd = 1'b1;
            S_RAD:    o_cmd.rad = 1'b1;
            S_RSQ:    o_cmd.rsq = 1'b1;
            S_DONE:   o_cmd.out_load = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open <= 1'b0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_cmd.load) r_state <= S_DIFF;
                S_DIFF: begin r_state <= S_SQ; r_cnt <= '0; end
                S_SQ: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd2) r_state <= S_CMP;
                end
                S_CMP: r_state <= S_DEC;
                S_DEC: begin
                    r_cnt <= '0;
                    r_state <= i_sts.outside ? S_ROOT : S_DONE;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) r_state <= S_RFIN;
                end
                S_RFIN: r_state <= S_DSTART;
                S_DSTART: begin r_state <= S_DIV; r_cnt <= '0; end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin r_state <= S_MUL; r_cnt <= '0; end
                end
                S_MUL: r_state <= S_UPD;
                S_UPD: begin
                    if (r_cnt == 6'd2) r_state <= S_RAD;
                    else begin r_cnt <= r_cnt + 6'd1; r_state <= S_MUL; end
                end
                S_RAD: r_state <= S_RSQ;
                S_RSQ: r_state <= S_DONE;
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_open <= !i_sts.last;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/incremental_bounding_sphere_unit.sv
// Top level of the incremental bounding sphere unit.
// Channel | Direction | Handshake
// in      | input     | i_in_valid / o_in_stall
// out     | output    | o_out_valid / i_out_stall
// cfg     | input     | i_cfg_valid / o_cfg_ready
// An inside point passes through the DIFF, SQ, CMP, DEC and DONE states before
// the unit returns to idle for the next input transfer. An outside point also runs
// the 33-step square root and the 32-step fraction divide on the shared datapath.
// Reset is synchronous, clears control state and the box registers, and holds
// off input and configuration transfers while it is low.
// A held result stalls new input until it is transferred.
module incremental_bounding_sphere_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ibs_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ibs_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ibs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ibs_pkg::COORD_WIDTH-1:0] i_cfg_data
);
    import ibs_pkg::*;
    `include "assert_macros.svh"

    logic signed [31:0] r_bmin [3];
    logic signed [31:0] r_bmax [3];
    t_cmd s_cmd;
    t_sts s_sts;

    assign o_cfg_ready = i_rst_n;

    // Box registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_bmin[a] <= '0;
                r_bmax[a] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_X: r_bmin[0] <= 32'(signed'(i_cfg_data));
                CFG_MIN_Y: r_bmin[1] <= 32'(signed'(i_cfg_data));
                CFG_MIN_Z: r_bmin[2] <= 32'(signed'(i_cfg_data));
                CFG_MAX_X: r_bmax[0] <= 32'(signed'(i_cfg_data));
                CFG_MAX_Y: r_bmax[1] <= 32'(signed'(i_cfg_data));
                CFG_MAX_Z: r_bmax[2] <= 32'(signed'(i_cfg_data));
                default: ;
            endcase
        end
    end

    ibs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_sts(s_sts), .o_cmd(s_cmd)
    );

    ibs_datapath u_dp (
        .i_clk, .i_item(i_in_data), .i_cmd(s_cmd),
        .i_box_min(r_bmin), .i_box_max(r_bmax),
        .o_sts(s_sts), .o_item(o_out_data)
    );

    `IBS_ASSERT_NEXT(a_out_after_done, i_clk, i_rst_n, s_cmd.out_load, o_out_valid, "no result after done")
    `IBS_ASSERT_IMPL(a_no_load_busy, i_clk, i_rst_n, s_cmd.load, !o_out_valid || !i_out_stall, "load while result held")
    `IBS_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({s_cmd.sqrt_step, s_cmd.div_step, s_cmd.upd}), "overlapping commands")
endmodule
